// ===== rtl/core/tfu_pkg.sv =====
package tfu_pkg;

    // default number of series terms after the leading one
    localparam int TFU_TERMS = 10;

    // Q48 constants
    localparam logic signed [63:0] TFU_PI     = 64'h0003243F6A8885A3;
    localparam logic signed [63:0] TFU_HALF   = 64'h0001921FB54442D1;
    localparam logic signed [63:0] TFU_TWO_PI = 64'h0006487ED5110B46;
    localparam logic signed [63:0] TFU_ONE    = 64'h0001000000000000;
    localparam logic [63:0]        TFU_EPS    = 64'd281475;
    localparam logic [63:0]        TFU_INF2   = 64'd20000000000;

    // degree constants in Q16.16
    localparam logic [63:0] TFU_DEG360  = 64'd23592960;
    localparam logic [63:0] TFU_DEG180  = 64'd11796480;
    localparam logic [63:0] TFU_DEG_RND = 64'd5898240;

    // saturation values in Q24.24
    localparam logic [47:0] TFU_MAXV    = 48'h7FFFFFFFFFFF;
    localparam logic [47:0] TFU_SAT_NEG = 48'h800000000001;

    // function select codes
    localparam logic [1:0] TFU_SIN = 2'd0;
    localparam logic [1:0] TFU_COS = 2'd1;
    localparam logic [1:0] TFU_TAN = 2'd2;
    localparam logic [1:0] TFU_COT = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RAD_DIV,
        ST_RAD_FIX,
        ST_DEG_DIV,
        ST_DEG_WRAP,
        ST_DEG_MUL,
        ST_DEG_ADD,
        ST_DEG_SCALE,
        ST_DEG_FIX,
        ST_FOLD,
        ST_SQ_MUL,
        ST_SQ_RND,
        ST_SER_INIT,
        ST_SER_MUL,
        ST_SER_RND,
        ST_SER_DIV,
        ST_SER_ACC,
        ST_FIN,
        ST_INF_MUL,
        ST_INF_CMP,
        ST_TAN_DIV,
        ST_TAN_FIN,
        ST_OUT
    } tfu_state_t;

    // magnitude of a signed Q48 value
    function automatic logic [63:0] tfu_abs(input logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // values below epsilon become zero
    function automatic logic signed [63:0] tfu_flush(input logic signed [63:0] v);
        return (tfu_abs(v) < TFU_EPS) ? 64'sd0 : v;
    endfunction

    // Q48 magnitude to Q24.24 with round half up
    function automatic logic [40:0] tfu_q24(input logic [63:0] m);
        return {1'b0, m[63:24]} + {40'd0, m[23]};
    endfunction

    // series term divisor for term i
    function automatic logic [10:0] tfu_series_div(input logic [4:0] i, input logic odd);
        logic [10:0] two_i;
        logic [21:0] p;
        two_i = {5'd0, i, 1'b0};
        p = odd ? (two_i + 11'd1) * two_i : (two_i - 11'd1) * two_i;
        return p[10:0];
    endfunction

endpackage

// ===== rtl/core/trig_function_unit.sv =====
// Sine, cosine, tangent or cotangent of one signed Q16.16 angle (radians or
// degrees) per transaction, result in signed Q24.24 with a saturation flag.
// All arithmetic runs through one bit-serial shift-add multiplier and one
// bit-serial restoring divider, so latency is set by how many series terms are
// needed, with extra steps for degree input and for tan or cot. One item is in
// flight at a time; in_stall is high from acceptance until the result
// transaction on the output side.
module trig_function_unit #(
    parameter int TERMS = tfu_pkg::TFU_TERMS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] angle,
    input  logic [1:0]         mode,
    input  logic               in_degrees,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [47:0] value,
    output logic               saturated
);
    import tfu_pkg::*;

    localparam int IW = $clog2(TERMS + 1);

    tfu_state_t state_reg, state_next;
    logic [7:0] cnt_reg, cnt_next;
    logic       ovalid_reg, ovalid_next;

    logic               aneg_reg, aneg_next;
    logic [1:0]         mode_reg, mode_next;
    logic [63:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic [63:0]        phi_reg, phi_next, plo_reg, plo_next;
    logic [127:0]       dnum_reg, dnum_next;
    logic [63:0]        drem_reg, drem_next, dden_reg, dden_next;
    logic signed [63:0] x_reg, x_next;
    logic               xneg_reg, xneg_next;
    logic               outer_reg, outer_next;
    logic [63:0]        sq_reg, sq_next;
    logic signed [63:0] term_reg, term_next, sum_reg, sum_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               odd_reg, odd_next;
    logic signed [63:0] s_reg, s_next, c_reg, c_next;
    logic [63:0]        nm_reg, nm_next, dm_reg, dm_next;
    logic               qneg_reg, qneg_next;
    logic [47:0]        value_reg, value_next;
    logic               sat_reg, sat_next;

    // shared bit-serial multiplier step
    logic [64:0]  mul_sum;
    logic [127:0] prod;
    logic [63:0]  prod_rnd;
    assign mul_sum  = {1'b0, phi_reg} + (mb_reg[0] ? {1'b0, ma_reg} : 65'd0);
    assign prod     = {phi_reg, plo_reg};
    assign prod_rnd = prod[111:48] + {63'd0, prod[47]};

    // shared restoring divider step
    logic [64:0] rem_sh, rem_sub;
    logic        div_ge;
    assign rem_sh  = {drem_reg, dnum_reg[127]};
    assign div_ge  = rem_sh >= {1'b0, dden_reg};
    assign rem_sub = rem_sh - {1'b0, dden_reg};

    // input magnitude
    logic [31:0] ang_mag;
    assign ang_mag = angle[31] ? (~angle + 32'd1) : angle;

    // radian reduction result
    logic [63:0]        rad_wrap;
    logic signed [63:0] rad_x;
    assign rad_wrap = TFU_TWO_PI - drem_reg;
    always_comb
    begin
        if (drem_reg > TFU_PI)
            rad_x = aneg_reg ? rad_wrap : (~rad_wrap + 64'd1);
        else
            rad_x = aneg_reg ? (~drem_reg + 64'd1) : drem_reg;
    end

    // degree wrap into [-180, 180]
    logic        dw_big;
    logic [63:0] dw_mag;
    assign dw_big = drem_reg > TFU_DEG180;
    assign dw_mag = dw_big ? (TFU_DEG360 - drem_reg) : drem_reg;

    // fold into [-pi/2, pi/2]
    logic signed [63:0] fold_x;
    logic               fold_outer;
    always_comb
    begin
        if (x_reg > TFU_HALF)
        begin
            fold_x     = TFU_PI - x_reg;
            fold_outer = 1'b1;
        end
        else if (x_reg < -TFU_HALF)
        begin
            fold_x     = -TFU_PI - x_reg;
            fold_outer = 1'b1;
        end
        else
        begin
            fold_x     = x_reg;
            fold_outer = 1'b0;
        end
    end

    // series term update
    logic [10:0]        ser_dv;
    logic [63:0]        ser_m;
    logic signed [63:0] ser_term, ser_sum, ser_cos;
    logic               ser_done;
    logic signed [63:0] init_term;
    assign ser_dv    = tfu_series_div(5'(idx_reg), odd_reg);
    assign ser_m     = dnum_reg[63:0];
    assign ser_term  = term_reg[63] ? ser_m : (~ser_m + 64'd1);
    assign ser_sum   = sum_reg + ser_term;
    assign ser_cos   = outer_reg ? -ser_sum : ser_sum;
    assign ser_done  = (ser_m < TFU_EPS) || (idx_reg == IW'(TERMS));
    assign init_term = odd_reg ? x_reg : TFU_ONE;

    // final selection for sin and cos, and quotient operands for tan and cot
    logic signed [63:0] fin_v, fin_num, fin_den;
    logic [40:0]        fin_r;
    assign fin_v   = (mode_reg == TFU_SIN) ? s_reg : c_reg;
    assign fin_r   = tfu_q24(tfu_abs(fin_v));
    assign fin_num = (mode_reg == TFU_TAN) ? s_reg : c_reg;
    assign fin_den = (mode_reg == TFU_TAN) ? c_reg : s_reg;

    // quotient checks
    logic        inf_hit, inf_neg;
    logic [40:0] tan_r;
    assign inf_hit = prod <= {64'd0, nm_reg};
    assign inf_neg = s_reg[63] != c_reg[63];
    assign tan_r   = tfu_q24(dnum_reg[63:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = in_degrees ? ST_DEG_DIV : ST_RAD_DIV;
            ST_RAD_DIV:   if (cnt_reg == 8'd0) state_next = ST_RAD_FIX;
            ST_RAD_FIX:   state_next = ST_FOLD;
            ST_DEG_DIV:   if (cnt_reg == 8'd0) state_next = ST_DEG_WRAP;
            ST_DEG_WRAP:  state_next = ST_DEG_MUL;
            ST_DEG_MUL:   if (cnt_reg == 8'd0) state_next = ST_DEG_ADD;
            ST_DEG_ADD:   state_next = ST_DEG_SCALE;
            ST_DEG_SCALE: if (cnt_reg == 8'd0) state_next = ST_DEG_FIX;
            ST_DEG_FIX:   state_next = ST_FOLD;
            ST_FOLD:      state_next = ST_SQ_MUL;
            ST_SQ_MUL:    if (cnt_reg == 8'd0) state_next = ST_SQ_RND;
            ST_SQ_RND:    state_next = ST_SER_INIT;
            ST_SER_INIT:  state_next = ST_SER_MUL;
            ST_SER_MUL:   if (cnt_reg == 8'd0) state_next = ST_SER_RND;
            ST_SER_RND:   state_next = ST_SER_DIV;
            ST_SER_DIV:   if (cnt_reg == 8'd0) state_next = ST_SER_ACC;
            ST_SER_ACC:
            begin
                if (!ser_done)
                    state_next = ST_SER_MUL;
                else
                    state_next = odd_reg ? ST_SER_INIT : ST_FIN;
            end
            ST_FIN:       state_next = (mode_reg == TFU_SIN || mode_reg == TFU_COS) ?
                                       ST_OUT : ST_INF_MUL;
            ST_INF_MUL:   if (cnt_reg == 8'd0) state_next = ST_INF_CMP;
            ST_INF_CMP:   state_next = inf_hit ? ST_OUT : ST_TAN_DIV;
            ST_TAN_DIV:   if (cnt_reg == 8'd0) state_next = ST_TAN_FIN;
            ST_TAN_FIN:   state_next = ST_OUT;
            ST_OUT:       if (!out_stall) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        aneg_next   = aneg_reg;
        mode_next   = mode_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        phi_next    = phi_reg;
        plo_next    = plo_reg;
        dnum_next   = dnum_reg;
        drem_next   = drem_reg;
        dden_next   = dden_reg;
        x_next      = x_reg;
        xneg_next   = xneg_reg;
        outer_next  = outer_reg;
        sq_next     = sq_reg;
        term_next   = term_reg;
        sum_next    = sum_reg;
        idx_next    = idx_reg;
        odd_next    = odd_reg;
        s_next      = s_reg;
        c_next      = c_reg;
        nm_next     = nm_reg;
        dm_next     = dm_reg;
        qneg_next   = qneg_reg;
        value_next  = value_reg;
        sat_next    = sat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    aneg_next = angle[31];
                    mode_next = mode;
                    drem_next = 64'd0;
                    if (in_degrees)
                    begin
                        dnum_next = {ang_mag, 96'd0};
                        dden_next = TFU_DEG360;
                        cnt_next  = 8'd31;
                    end
                    else
                    begin
                        dnum_next = {ang_mag, 96'd0};
                        dden_next = TFU_TWO_PI;
                        cnt_next  = 8'd63;
                    end
                end
            end
            ST_RAD_DIV, ST_DEG_DIV, ST_DEG_SCALE, ST_SER_DIV, ST_TAN_DIV:
            begin
                drem_next = div_ge ? rem_sub[63:0] : rem_sh[63:0];
                dnum_next = {dnum_reg[126:0], div_ge};
                cnt_next  = cnt_reg - 8'd1;
            end
            ST_DEG_MUL, ST_SQ_MUL, ST_SER_MUL, ST_INF_MUL:
            begin
                phi_next = mul_sum[64:1];
                plo_next = {mul_sum[0], plo_reg[63:1]};
                mb_next  = mb_reg >> 1;
                cnt_next = cnt_reg - 8'd1;
            end
            ST_RAD_FIX:
            begin
                x_next = rad_x;
            end
            ST_DEG_WRAP:
            begin
                xneg_next = dw_big ? !aneg_reg : aneg_reg;
                ma_next   = dw_mag;
                mb_next   = TFU_PI;
                phi_next  = 64'd0;
                plo_next  = 64'd0;
                cnt_next  = 8'd63;
            end
            ST_DEG_ADD:
            begin
                dnum_next = prod + {64'd0, TFU_DEG_RND};
                drem_next = 64'd0;
                dden_next = TFU_DEG180;
                cnt_next  = 8'd127;
            end
            ST_DEG_FIX:
            begin
                x_next = xneg_reg ? (~dnum_reg[63:0] + 64'd1) : dnum_reg[63:0];
            end
            ST_FOLD:
            begin
                x_next     = fold_x;
                outer_next = fold_outer;
                ma_next    = tfu_abs(fold_x);
                mb_next    = tfu_abs(fold_x);
                phi_next   = 64'd0;
                plo_next   = 64'd0;
                cnt_next   = 8'd63;
            end
            ST_SQ_RND:
            begin
                sq_next  = prod_rnd;
                odd_next = 1'b1;
            end
            ST_SER_INIT:
            begin
                term_next = init_term;
                sum_next  = init_term;
                idx_next  = IW'(1);
                ma_next   = tfu_abs(init_term);
                mb_next   = sq_reg;
                phi_next  = 64'd0;
                plo_next  = 64'd0;
                cnt_next  = 8'd63;
            end
            ST_SER_RND:
            begin
                dnum_next = {prod_rnd + {54'd0, ser_dv[10:1]}, 64'd0};
                drem_next = 64'd0;
                dden_next = {53'd0, ser_dv};
                cnt_next  = 8'd63;
            end
            ST_SER_ACC:
            begin
                term_next = ser_term;
                sum_next  = ser_sum;
                if (!ser_done)
                begin
                    idx_next = idx_reg + IW'(1);
                    ma_next  = ser_m;
                    mb_next  = sq_reg;
                    phi_next = 64'd0;
                    plo_next = 64'd0;
                    cnt_next = 8'd63;
                end
                else if (odd_reg)
                begin
                    s_next   = tfu_flush(ser_sum);
                    odd_next = 1'b0;
                end
                else
                begin
                    c_next = tfu_flush(ser_cos);
                end
            end
            ST_FIN:
            begin
                if (mode_reg == TFU_SIN || mode_reg == TFU_COS)
                begin
                    value_next  = fin_v[63] ? (~{7'd0, fin_r} + 48'd1) : {7'd0, fin_r};
                    sat_next    = 1'b0;
                    ovalid_next = 1'b1;
                end
                else
                begin
                    nm_next   = tfu_abs(fin_num);
                    dm_next   = tfu_abs(fin_den);
                    qneg_next = fin_num[63] != fin_den[63];
                    ma_next   = tfu_abs(fin_den);
                    mb_next   = TFU_INF2;
                    phi_next  = 64'd0;
                    plo_next  = 64'd0;
                    cnt_next  = 8'd63;
                end
            end
            ST_INF_CMP:
            begin
                if (inf_hit)
                begin
                    value_next  = inf_neg ? TFU_SAT_NEG : TFU_MAXV;
                    sat_next    = 1'b1;
                    ovalid_next = 1'b1;
                end
                else
                begin
                    dnum_next = {16'd0, nm_reg, 48'd0} + {65'd0, dm_reg[63:1]};
                    drem_next = 64'd0;
                    dden_next = dm_reg;
                    cnt_next  = 8'd127;
                end
            end
            ST_TAN_FIN:
            begin
                ovalid_next = 1'b1;
                if (dnum_reg[127:64] != 64'd0 || {7'd0, tan_r} > TFU_MAXV)
                begin
                    value_next = qneg_reg ? TFU_SAT_NEG : TFU_MAXV;
                    sat_next   = 1'b1;
                end
                else if (dnum_reg[63:0] < TFU_EPS)
                begin
                    value_next = 48'd0;
                    sat_next   = 1'b0;
                end
                else
                begin
                    value_next = qneg_reg ? (~{7'd0, tan_r} + 48'd1) : {7'd0, tan_r};
                    sat_next   = 1'b0;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                    ovalid_next = 1'b0;
            end
            default:
            begin
                ovalid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 8'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        aneg_reg  <= aneg_next;
        mode_reg  <= mode_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        phi_reg   <= phi_next;
        plo_reg   <= plo_next;
        dnum_reg  <= dnum_next;
        drem_reg  <= drem_next;
        dden_reg  <= dden_next;
        x_reg     <= x_next;
        xneg_reg  <= xneg_next;
        outer_reg <= outer_next;
        sq_reg    <= sq_next;
        term_reg  <= term_next;
        sum_reg   <= sum_next;
        idx_reg   <= idx_next;
        odd_reg   <= odd_next;
        s_reg     <= s_next;
        c_reg     <= c_next;
        nm_reg    <= nm_next;
        dm_reg    <= dm_next;
        qneg_reg  <= qneg_next;
        value_reg <= value_next;
        sat_reg   <= sat_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;
    assign value     = value_reg;
    assign saturated = sat_reg;

`ifndef ASSERT_OFF
    // a pending result always blocks new input
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("result pending while input open");

    // a saturated result carries the full-scale magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (value == TFU_MAXV || value == TFU_SAT_NEG))
        else $error("saturated result without full-scale value");

    // a delivered result is not repeated
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result repeated after transaction");
`endif

endmodule
